>>> rtl/gmdfs_pkg.sv
package gmdfs_pkg;

  // Default capacity of the maze store in cells.
  localparam int unsigned MaxCellsDef = 4096;

  // Directions tried at each cell: -x, +x, -y, +y, -z, +z.
  localparam int unsigned NumDirs = 6;

  // Widths fixed by the interface.
  localparam int unsigned SizeW  = 13;
  localparam int unsigned CoordW = 12;
  localparam int unsigned LenW   = 12;
  localparam int unsigned PassW  = 6;
  localparam int unsigned DirW   = 3;

  // Configuration register indexes.
  localparam logic [1:0] CfgSizeX = 2'd0;
  localparam logic [1:0] CfgSizeY = 2'd1;
  localparam logic [1:0] CfgSizeZ = 2'd2;
  localparam logic [1:0] CfgHome  = 2'd3;

  // Result status codes.
  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StSizeErr  = 2'd2;

  // Write and read request for the path stack.
  typedef struct packed {
    logic we;
    logic re;
  } stk_ctrl_t;

endpackage

>>> rtl/gmdfs_stack.sv
module gmdfs_stack import gmdfs_pkg::*; #(
  parameter int unsigned Depth = MaxCellsDef,
  parameter int unsigned DataW = 8
) (
  input  logic                     clk_i,
  input  stk_ctrl_t                ctrl_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  // Single write port, single registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/grid_maze_dfs_path_length_core.sv
// Depth-first maze walker. A load beat (tuser = 0) writes one cell's passage mask and food
// flag. A start beat (tuser = 1) multiplies out the grid size, then clears the visited
// memory in one pass over all MAX_CELLS cells while it locates the home cell's coordinates,
// and then walks: each direction is tried in turn, an open neighbor is checked in the
// visited memory, a push fetches the new cell from the cell store, and a pop reads the
// saved cell back from the path stack. A size error is answered at the start of the sweep,
// before any visited bit is cleared.
// The block takes no beat during a walk; a finished result waits in the output register.
module grid_maze_dfs_path_length_core import gmdfs_pkg::*; #(
  parameter int unsigned MAX_CELLS = MaxCellsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [12:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // cell_index[11:0], passages[17:12], has_food[18]
  input  logic        s_axis_tuser,   // mode[0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // path_length[11:0]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned AW   = $clog2(MAX_CELLS);
  localparam int unsigned DW   = AW + 3 * CoordW + DirW + PassW + 1;
  localparam int unsigned PlW  = 2 * SizeW;
  localparam int unsigned TotW = 3 * SizeW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_SWEEP = 4'd3;
  localparam logic [3:0] S_HOME  = 4'd4;
  localparam logic [3:0] S_LOAD  = 4'd5;
  localparam logic [3:0] S_STEP  = 4'd6;
  localparam logic [3:0] S_VCHK  = 4'd7;
  localparam logic [3:0] S_POP   = 4'd8;
  localparam logic [3:0] S_RES   = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [SizeW-1:0]  sx_q, sy_q, sz_q;
  logic [CoordW-1:0] home_q;
  logic [PlW-1:0]    plane_q, plane_d;
  logic [TotW-1:0]   total_q, total_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic [CoordW-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [AW-1:0]     top_q, top_d;
  logic [CoordW-1:0] tx_q, tx_d, ty_q, ty_d, tz_q, tz_d;
  logic [DirW-1:0]   dir_q, dir_d;
  logic [PassW-1:0]  pas_q, pas_d;
  logic              food_q, food_d;
  logic [AW:0]       depth_q, depth_d;
  logic [AW-1:0]     nb_q, nb_d;
  logic [CoordW-1:0] nx_q, nx_d, ny_q, ny_d, nz_q, nz_d;
  logic [1:0]        rst_q, rst_d;
  logic [LenW-1:0]   rlen_q, rlen_d;
  logic              mval_q, mval_d;
  logic [1:0]        mst_q, mst_d;
  logic [LenW-1:0]   mlen_q, mlen_d;

  logic              in_acc;
  logic [CoordW-1:0] in_idx;
  logic [PassW-1:0]  in_pas;
  logic              in_food;

  logic [PassW:0]    cell_mem [MAX_CELLS];
  logic [PassW:0]    cell_rd_q;
  logic              cell_we, cell_re;
  logic [AW-1:0]     cell_raddr;

  logic              vis_mem [MAX_CELLS];
  logic              vis_rd_q;
  logic              vis_we, vis_wd, vis_re;
  logic [AW-1:0]     vis_waddr, vis_raddr;

  stk_ctrl_t         stk_ctrl;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [DW-1:0]     stk_wdata, stk_rdata;

  logic              inb, dir_open;
  logic [AW:0]       len_full;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign in_idx  = s_axis_tdata[11:0];
  assign in_pas  = s_axis_tdata[17:12];
  assign in_food = s_axis_tdata[18];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {{(16 - LenW){1'b0}}, mlen_q};
  assign m_axis_tuser  = mst_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= SizeW'(16);
      sy_q   <= SizeW'(16);
      sz_q   <= SizeW'(16);
      home_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgSizeX: sx_q   <= cfg_data_i;
        CfgSizeY: sy_q   <= cfg_data_i;
        CfgSizeZ: sz_q   <= cfg_data_i;
        CfgHome:  home_q <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Cell store: loads write it, the walk reads one cell at a time.
  assign cell_we = in_acc & ~s_axis_tuser & (32'(in_idx) < MAX_CELLS);

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[AW'(in_idx)] <= {in_food, in_pas};
    end
    if (cell_re) begin
      cell_rd_q <= cell_mem[cell_raddr];
    end
  end

  // Visited bits: cleared by the sweep, set on entry to a cell.
  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wd;
    end
    if (vis_re) begin
      vis_rd_q <= vis_mem[vis_raddr];
    end
  end

  gmdfs_stack #(
    .Depth (MAX_CELLS),
    .DataW (DW)
  ) u_stack (
    .clk_i   (clk_i),
    .ctrl_i  (stk_ctrl),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Bounds check for the direction under test at the top cell.
  always_comb begin
    case (dir_q)
      3'd0:    inb = (tx_q != '0);
      3'd1:    inb = ({1'b0, tx_q} + 1'b1) < sx_q;
      3'd2:    inb = (ty_q != '0);
      3'd3:    inb = ({1'b0, ty_q} + 1'b1) < sy_q;
      3'd4:    inb = (tz_q != '0);
      3'd5:    inb = ({1'b0, tz_q} + 1'b1) < sz_q;
      default: inb = 1'b0;
    endcase
  end

  assign dir_open = pas_q[dir_q] & inb & (depth_q < (AW + 1)'(MAX_CELLS));
  assign len_full = depth_q - 1'b1;

  // Sequencer for search setup and the walk.
  always_comb begin
    state_d  = state_q;
    plane_d  = plane_q;
    total_d  = total_q;
    sweep_d  = sweep_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    top_d = top_q; tx_d = tx_q; ty_d = ty_q; tz_d = tz_q;
    dir_d = dir_q; pas_d = pas_q; food_d = food_q;
    depth_d = depth_q;
    nb_d = nb_q; nx_d = tx_q; ny_d = ty_q; nz_d = tz_q;
    rst_d = rst_q; rlen_d = rlen_q;
    mval_d = mval_q; mst_d = mst_q; mlen_d = mlen_q;
    cell_re = 1'b0; cell_raddr = top_q;
    vis_we = 1'b0; vis_wd = 1'b0; vis_waddr = sweep_q;
    vis_re = 1'b0; vis_raddr = top_q;
    stk_ctrl = '0;
    stk_waddr = depth_q[AW-1:0] - 1'b1;
    stk_wdata = {top_q, tx_q, ty_q, tz_q, dir_q, pas_q, food_q};
    stk_raddr = depth_q[AW-1:0] - 2'd2;

    if (mval_q && m_axis_tready) begin
      mval_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && s_axis_tuser) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        plane_d = sx_q * sy_q;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        total_d = plane_q * sz_q;
        sweep_d = '0;
        cx_d = '0; cy_d = '0; cz_d = '0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        // First pass checks the size and the home index; then clear one visited bit a cycle.
        if (sweep_q == '0 && total_q > TotW'(MAX_CELLS)) begin
          rst_d = StSizeErr; rlen_d = '0; state_d = S_RES;
        end else if (sweep_q == '0 && TotW'(home_q) >= total_q) begin
          rst_d = StNotFound; rlen_d = '0; state_d = S_RES;
        end else begin
          vis_we = 1'b1; vis_wd = 1'b0; vis_waddr = sweep_q;
          if (32'(sweep_q) == 32'(home_q)) begin
            tx_d = cx_q; ty_d = cy_q; tz_d = cz_q;
          end
          if (({1'b0, cx_q} + 1'b1) == sx_q) begin
            cx_d = '0;
            if (({1'b0, cy_q} + 1'b1) == sy_q) begin
              cy_d = '0;
              cz_d = cz_q + 1'b1;
            end else begin
              cy_d = cy_q + 1'b1;
            end
          end else begin
            cx_d = cx_q + 1'b1;
          end
          sweep_d = sweep_q + 1'b1;
          if (sweep_q == AW'(MAX_CELLS - 1)) begin
            state_d = S_HOME;
          end
        end
      end
      S_HOME: begin
        top_d = AW'(home_q);
        dir_d = '0;
        depth_d = (AW + 1)'(1);
        vis_we = 1'b1; vis_wd = 1'b1; vis_waddr = AW'(home_q);
        cell_re = 1'b1; cell_raddr = AW'(home_q);
        state_d = S_LOAD;
      end
      S_LOAD: begin
        pas_d  = cell_rd_q[PassW-1:0];
        food_d = cell_rd_q[PassW];
        state_d = S_STEP;
      end
      S_STEP: begin
        if (dir_q < DirW'(NumDirs)) begin
          dir_d = dir_q + 1'b1;
          if (dir_open) begin
            case (dir_q)
              3'd0: begin nb_d = top_q - 1'b1; nx_d = tx_q - 1'b1; end
              3'd1: begin nb_d = top_q + 1'b1; nx_d = tx_q + 1'b1; end
              3'd2: begin nb_d = top_q - AW'(sx_q); ny_d = ty_q - 1'b1; end
              3'd3: begin nb_d = top_q + AW'(sx_q); ny_d = ty_q + 1'b1; end
              3'd4: begin nb_d = top_q - AW'(plane_q); nz_d = tz_q - 1'b1; end
              default: begin nb_d = top_q + AW'(plane_q); nz_d = tz_q + 1'b1; end
            endcase
            vis_re = 1'b1; vis_raddr = nb_d;
            state_d = S_VCHK;
          end
        end else if (food_q) begin
          rst_d = StFound;
          rlen_d = (len_full > (AW + 1)'(2 ** LenW - 1)) ? {LenW{1'b1}} : LenW'(len_full);
          state_d = S_RES;
        end else if (depth_q == (AW + 1)'(1)) begin
          rst_d = StNotFound; rlen_d = '0; state_d = S_RES;
        end else begin
          stk_ctrl.re = 1'b1;
          depth_d = depth_q - 1'b1;
          state_d = S_POP;
        end
      end
      S_VCHK: begin
        nx_d = nx_q; ny_d = ny_q; nz_d = nz_q;
        if (vis_rd_q) begin
          state_d = S_STEP;
        end else begin
          vis_we = 1'b1; vis_wd = 1'b1; vis_waddr = nb_q;
          stk_ctrl.we = 1'b1;
          top_d = nb_q; tx_d = nx_q; ty_d = ny_q; tz_d = nz_q;
          dir_d = '0;
          depth_d = depth_q + 1'b1;
          cell_re = 1'b1; cell_raddr = nb_q;
          state_d = S_LOAD;
        end
      end
      S_POP: begin
        {top_d, tx_d, ty_d, tz_d, dir_d, pas_d, food_d} = stk_rdata;
        state_d = S_STEP;
      end
      S_RES: begin
        if (!mval_q || m_axis_tready) begin
          mval_d = 1'b1; mst_d = rst_q; mlen_d = rlen_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      mval_q  <= mval_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    plane_q <= plane_d; total_q <= total_d; sweep_q <= sweep_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    top_q <= top_d; tx_q <= tx_d; ty_q <= ty_d; tz_q <= tz_d;
    dir_q <= dir_d; pas_q <= pas_d; food_q <= food_d;
    nb_q <= nb_d; nx_q <= nx_d; ny_q <= ny_d; nz_q <= nz_d;
    rst_q <= rst_d; rlen_q <= rlen_d;
    mst_q <= mst_d; mlen_q <= mlen_d;
  end

  // The stack never grows past the store.
  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= (AW + 1)'(MAX_CELLS)) else $error("stack depth overflow");

  // The walk never runs with an empty stack.
  a_depth_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP || state_q == S_VCHK || state_q == S_LOAD) |-> depth_q != '0)
    else $error("walk with empty stack");

  // A push onto an unvisited neighbor grows the stack by one.
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VCHK && !vis_rd_q) |=> depth_q == $past(depth_q) + 1'b1)
    else $error("push did not grow stack");

  // A new result only comes from the result state.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_RES) else $error("stray result");

endmodule
